/* hw/rtl/multi_standard_crc_engine_core_assert.svh */
// ----------------------------------------------------------------------------
// CRC engine assertion macros
// Concurrent checks used by the CRC engine core RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_STANDARD_CRC_ENGINE_CORE_ASSERT_SVH
`define MULTI_STANDARD_CRC_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MSCRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("CRC engine check failed");

// Next-cycle implication, disabled while reset is held.
`define MSCRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("CRC engine check failed");

`endif

/* hw/rtl/mscrc_pkg.sv */
// ----------------------------------------------------------------------------
// CRC engine package
// Mode codes, per-mode constants, item and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package mscrc_pkg;

  typedef enum logic [2:0] {
    MODE_CRC8_J1850 = 3'd0,
    MODE_CRC8_H2F   = 3'd1,
    MODE_CRC16_CCITT = 3'd2,
    MODE_CRC16_ARC  = 3'd3,
    MODE_CRC32      = 3'd4,
    MODE_CRC32P4    = 3'd5,
    MODE_CRC64      = 3'd6
  } crc_mode_t;

  localparam logic [2:0] MODE_UNUSED_CODE = 3'd7;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // one accepted input word
  typedef struct packed {
    logic [63:0] start_value;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        block_start;
    logic        block_end;
    logic        first_call;
  } item_t;

  // running calculation state
  typedef struct packed {
    logic [63:0] crc;
    logic        in_block;
    logic        pending;  // CRC64 empty-start: reload init on first byte
  } state_t;

  function automatic logic [63:0] mode_mask(crc_mode_t m);
    logic [63:0] r;
    unique case (m)
      MODE_CRC8_J1850, MODE_CRC8_H2F:  r = 64'h0000_0000_0000_00FF;
      MODE_CRC16_CCITT, MODE_CRC16_ARC: r = 64'h0000_0000_0000_FFFF;
      MODE_CRC32, MODE_CRC32P4:         r = 64'h0000_0000_FFFF_FFFF;
      MODE_CRC64:                       r = ALL_ONES;
      default:                          r = 64'h0000_0000_FFFF_FFFF;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mode_poly(crc_mode_t m);
    logic [63:0] r;
    unique case (m)
      MODE_CRC8_J1850:  r = 64'h0000_0000_0000_001D;
      MODE_CRC8_H2F:    r = 64'h0000_0000_0000_002F;
      MODE_CRC16_CCITT: r = 64'h0000_0000_0000_1021;
      MODE_CRC16_ARC:   r = 64'h0000_0000_0000_A001;
      MODE_CRC32:       r = 64'h0000_0000_EDB8_8320;
      MODE_CRC32P4:     r = 64'h0000_0000_C8DF_352F;
      MODE_CRC64:       r = 64'hC96C_5795_D787_0F42;
      default:          r = 64'h0000_0000_EDB8_8320;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mode_init(crc_mode_t m);
    logic [63:0] r;
    unique case (m)
      MODE_CRC16_ARC: r = 64'h0;
      default:        r = mode_mask(m);
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mode_xorout(crc_mode_t m);
    logic [63:0] r;
    unique case (m)
      MODE_CRC16_CCITT, MODE_CRC16_ARC: r = 64'h0;
      default:                          r = mode_mask(m);
    endcase
    return r;
  endfunction

  function automatic logic mode_reflected(crc_mode_t m);
    logic r;
    unique case (m)
      MODE_CRC8_J1850, MODE_CRC8_H2F, MODE_CRC16_CCITT: r = 1'b0;
      default:                                          r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/multi_standard_crc_engine_core.sv */
// ----------------------------------------------------------------------------
// Multi-standard CRC engine
// Byte-stream CRC over seven selectable CRC8/16/32/64 standards.
// ----------------------------------------------------------------------------
// The engine takes one message byte per input word and folds it into the
// running CRC of the mode selected in cfg_data (0 CRC8 SAE-J1850, 1 CRC8 0x2F,
// 2 CRC16 CCITT, 3 CRC16 ARC, 4 CRC32, 5 CRC32P4, 6 CRC64; code 7 is dropped).
// A word with block_start loads the register from the mode's init value or,
// with first_call low, from start_value with the output xor removed; a word
// with block_end returns the finished CRC, zero-extended to 64 bits. Words
// outside a block are dropped without a result. Throughput is one word per
// clock: a word is registered on input, the whole byte fold is one XOR
// network feeding the CRC register and the result register, so out_tvalid
// rises with the edge on which the word leaves the input register. A result
// waiting on out_tready holds off the next word only if that word would
// also produce a result.
// Change the mode only while no block is open and all results are taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_standard_crc_engine_core_assert.svh"

module multi_standard_crc_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,     // crc_mode
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,     // [7:0] data_byte, [71:8] start_value
  input  logic [2:0]  in_tuser,     // [0] has_byte, [1] block_start, [2] first_call
  input  logic        in_tlast,     // block_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata     // [63:0] crc_result
);

  mscrc_pkg::crc_mode_t mode_r;

  // input stage
  logic             s1_valid_r;
  mscrc_pkg::item_t s1_item_r;
  logic             s1_adv;

  // running state
  mscrc_pkg::state_t state_r;
  mscrc_pkg::state_t state_nxt;
  logic              emit;
  logic [63:0]       result;

  // result register
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_free;

  // Configuration is always taken; an unused mode code is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mscrc_pkg::MODE_CRC32;
    end else if (cfg_valid && cfg_ready && cfg_data != mscrc_pkg::MODE_UNUSED_CODE) begin
      mode_r <= mscrc_pkg::crc_mode_t'(cfg_data);
    end
  end

  mscrc_update u_update (
    .mode      (mode_r),
    .item      (s1_item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .emit      (emit),
    .result    (result)
  );

  // Advance the input stage unless it holds a result-producing word and the
  // result register is still occupied.
  assign out_free  = ~out_valid_r | out_tready;
  assign s1_adv    = s1_valid_r & (~emit | out_free);
  assign in_tready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.data_byte   <= in_tdata[7:0];
      s1_item_r.start_value <= in_tdata[71:8];
      s1_item_r.has_byte    <= in_tuser[0];
      s1_item_r.block_start <= in_tuser[1];
      s1_item_r.first_call  <= in_tuser[2];
      s1_item_r.block_end   <= in_tlast;
    end
  end

  // Commit the calculation state as the word leaves the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A CRC64 pending reload only exists inside an open block.
  `MSCRC_ASSERT_NOW(a_pending_in_block, clk, rst_n, state_r.pending, state_r.in_block)
  // A result-producing word that leaves the input stage shows up at the output.
  `MSCRC_ASSERT_NEXT(a_emit_reaches_out, clk, rst_n, s1_adv && emit, out_valid_r)
  // A blocked result-producing word stays in the input stage.
  `MSCRC_ASSERT_NEXT(a_blocked_word_held, clk, rst_n,
    s1_valid_r && emit && out_valid_r && !out_tready, s1_valid_r)

endmodule

`default_nettype wire

/* hw/rtl/mscrc_update.sv */
// ----------------------------------------------------------------------------
// CRC engine update logic
// Next state and result for one item: block start load, byte fold, block end.
// ----------------------------------------------------------------------------
`default_nettype none

module mscrc_update (
  input  var mscrc_pkg::crc_mode_t mode,
  input  var mscrc_pkg::item_t     item,
  input  var mscrc_pkg::state_t    state,
  output var mscrc_pkg::state_t    state_nxt,
  output logic                     emit,
  output logic [63:0]              result
);

  logic [63:0] mask;
  logic [63:0] poly;
  logic [63:0] init;
  logic [63:0] xorout;
  logic [63:0] top_bit;
  logic        refl;
  logic        active;
  logic [63:0] crc_load;
  logic        pend_load;
  logic [63:0] fold;

  assign mask    = mscrc_pkg::mode_mask(mode);
  assign poly    = mscrc_pkg::mode_poly(mode);
  assign init    = mscrc_pkg::mode_init(mode);
  assign xorout  = mscrc_pkg::mode_xorout(mode);
  assign refl    = mscrc_pkg::mode_reflected(mode);
  assign top_bit = mask ^ (mask >> 1);
  assign active  = item.block_start | state.in_block;

  // block start load
  always_comb begin
    crc_load  = state.crc;
    pend_load = state.pending;
    if (item.block_start) begin
      pend_load = 1'b0;
      if (mode == mscrc_pkg::MODE_CRC64 && item.first_call) begin
        crc_load  = item.start_value ^ xorout;
        pend_load = 1'b1;
      end else if (item.first_call) begin
        crc_load = init;
      end else begin
        crc_load = ((item.start_value & mask) ^ xorout) & mask;
      end
    end
  end

  // fold one byte: eight serial steps, flattened into an XOR network
  always_comb begin
    fold = crc_load;
    if (item.has_byte) begin
      if (pend_load && mode == mscrc_pkg::MODE_CRC64) begin
        fold = init;
      end
      fold = fold & mask;
      if (refl) begin
        fold = fold ^ {56'b0, item.data_byte};
        for (int i = 0; i < 8; i++) begin
          fold = fold[0] ? ((fold >> 1) ^ poly) : (fold >> 1);
        end
      end else begin
        if (mask == 64'h0000_0000_0000_00FF) begin
          fold = fold ^ {56'b0, item.data_byte};
        end else begin
          fold = fold ^ {48'b0, item.data_byte, 8'b0};
        end
        for (int i = 0; i < 8; i++) begin
          fold = ((fold & top_bit) != 64'h0) ? (((fold << 1) ^ poly) & mask)
                                             : ((fold << 1) & mask);
        end
      end
      fold = fold & mask;
    end
  end

  always_comb begin
    state_nxt = state;
    if (active) begin
      state_nxt.crc      = fold;
      state_nxt.in_block = ~item.block_end;
      state_nxt.pending  = item.block_end ? 1'b0 : (item.has_byte ? 1'b0 : pend_load);
    end
  end

  assign emit   = active & item.block_end;
  assign result = ((fold & mask) ^ xorout) & mask;

endmodule

`default_nettype wire
